### sv/gda_pkg.sv
`timescale 1ns / 1ps
// Shared types, month codes and calendar functions for the date advance block.
package gda_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 16;

  // Month codes.
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Action codes.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  localparam logic [YEAR_W-1:0] YEAR_MAX = 16'hFFFF;

  // Multiplicative inverse of 25 modulo 2^14 and the divisibility bound.
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] DIV25_MAX = 14'd655;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic done;
    logic wrap;
  } step_stat_t;

  // Leap-year test. Divisibility by 100 is checked as divisibility by 4 and
  // then of year/4 by 25, using the modular inverse of 25.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [27:0] prod;
    logic        div4;
    logic        div100;
    logic        div400;
    prod   = {14'd0, y[15:2]} * {14'd0, INV25};
    div4   = (y[1:0] == 2'd0);
    div100 = div4 && (prod[13:0] <= DIV25_MAX);
    div400 = div100 && (y[3:2] == 2'd0);
    return div4 && (!div100 || div400);
  endfunction

  // Length of a month in days; zero for a month code that means nothing.
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic [YEAR_W-1:0] y);
    logic [DAY_W-1:0] len;
    unique case (m)
      MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
      MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_FEB: len = is_leap(y) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

### sv/gda_step.sv
`timescale 1ns / 1ps
// Month step unit: moves a date forward by at most one month per use.
module gda_step import gda_pkg::*; #(
  parameter int ADVANCE_BITS = 16
) (
  input  date_t                   cur,
  input  logic [ADVANCE_BITS-1:0] days_left,
  output date_t                   nxt,
  output logic [ADVANCE_BITS-1:0] days_left_next,
  output step_stat_t              stat
);

  logic [DAY_W-1:0]        len;
  logic [DAY_W-1:0]        room;
  logic [ADVANCE_BITS-1:0] room_ext;
  logic                    fits;

  // Days remaining in the current month after the current day.
  assign len      = month_length(cur.month, cur.year);
  assign room     = len - cur.day;
  assign room_ext = ADVANCE_BITS'(room);
  assign fits     = (days_left <= room_ext);

  // Either finish inside this month or jump to the first of the next one.
  always_comb begin
    nxt            = cur;
    days_left_next = days_left;
    stat.done      = fits;
    stat.wrap      = 1'b0;
    if (fits) begin
      nxt.day        = cur.day + days_left[DAY_W-1:0];
      days_left_next = '0;
    end else begin
      days_left_next = days_left - room_ext - ADVANCE_BITS'(1);
      nxt.day        = 5'd1;
      if (cur.month != MONTH_DEC) begin
        nxt.month = cur.month + 4'd1;
      end else begin
        nxt.month = MONTH_JAN;
        nxt.year  = cur.year + 16'd1;
        stat.wrap = (cur.year == YEAR_MAX);
      end
    end
  end

endmodule

### sv/gregorian_date_advance.sv
`timescale 1ns / 1ps
// Top level: Gregorian date register with load and forward advance.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid, in_stall, action, load_day,           | in
//          | load_month, load_year, advance_days             |
//  output  | out_valid, out_stall, day, month, year,         | out
//          | load_error, year_wrapped                        |
//
// A load goes to ST_FIN. An advance steps in ST_RUN, one month boundary at
// most per step of the single month step unit, then to ST_FIN; 65535 days
// cross about 2150 months. One transaction is worked at a time; in_stall is
// high while it runs or while its result waits for the output register.
// Reset (rst, synchronous) sets the date to January 1 of year 0.
module gregorian_date_advance import gda_pkg::*; #(
  parameter int ADVANCE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    action,
  input  logic [DAY_W-1:0]        load_day,
  input  logic [MONTH_W-1:0]      load_month,
  input  logic [YEAR_W-1:0]       load_year,
  input  logic [ADVANCE_BITS-1:0] advance_days,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DAY_W-1:0]        day,
  output logic [MONTH_W-1:0]      month,
  output logic [YEAR_W-1:0]       year,
  output logic                    load_error,
  output logic                    year_wrapped
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t                  state;
  date_t                   cur;
  logic [ADVANCE_BITS-1:0] days_left;
  logic                    err;
  logic                    wrapped;

  date_t                   step_nxt;
  logic [ADVANCE_BITS-1:0] step_days_next;
  step_stat_t              step_stat;

  logic [DAY_W-1:0]        load_len;
  logic                    load_ok;
  logic                    out_free;

  gda_step #(
    .ADVANCE_BITS(ADVANCE_BITS)
  ) u_step (
    .cur           (cur),
    .days_left     (days_left),
    .nxt           (step_nxt),
    .days_left_next(step_days_next),
    .stat          (step_stat)
  );

  // Load check against the length of the loaded month.
  assign load_len = month_length(load_month, load_year);
  assign load_ok  = (load_len != 5'd0) && (load_day != 5'd0) && (load_day <= load_len);

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Sequencer, date state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cur.day      <= 5'd1;
      cur.month    <= MONTH_JAN;
      cur.year     <= '0;
      days_left    <= '0;
      err          <= 1'b0;
      wrapped      <= 1'b0;
      out_valid    <= 1'b0;
      day          <= '0;
      month        <= '0;
      year         <= '0;
      load_error   <= 1'b0;
      year_wrapped <= 1'b0;
    end else begin
      // A taken result is dropped unless a new one replaces it this cycle.
      if (out_valid && !out_stall && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            wrapped <= 1'b0;
            if (action == ACT_LOAD) begin
              err   <= !load_ok;
              state <= ST_FIN;
              if (load_ok) begin
                cur.day   <= load_day;
                cur.month <= load_month;
                cur.year  <= load_year;
              end
            end else begin
              err       <= 1'b0;
              days_left <= advance_days;
              state     <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          cur       <= step_nxt;
          days_left <= step_days_next;
          if (step_stat.wrap) begin
            wrapped <= 1'b1;
          end
          if (step_stat.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            day          <= cur.day;
            month        <= cur.month;
            year         <= cur.year;
            load_error   <= err;
            year_wrapped <= wrapped;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### verif/tb_gregorian_date_advance.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Gregorian date register with load and forward advance.
module tb_gregorian_date_advance;
  import gda_pkg::*;

  localparam int ADV_W        = 16;
  localparam int RANDOM_ITEMS = 250;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  // One date as returned by the block, with its two flags.
  typedef struct {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               load_error;
    logic               year_wrapped;
  } date_result_t;

  // One input transaction; known_result marks rows with a typed-in result.
  typedef struct {
    logic               act;
    logic [DAY_W-1:0]   ld;
    logic [MONTH_W-1:0] lm;
    logic [YEAR_W-1:0]  ly;
    logic [ADV_W-1:0]   adv;
    bit                 known_result;
    date_result_t       want;
  } date_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 action = ACT_LOAD;
  logic [DAY_W-1:0]     load_day = '0;
  logic [MONTH_W-1:0]   load_month = '0;
  logic [YEAR_W-1:0]    load_year = '0;
  logic [ADV_W-1:0]     advance_days = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DAY_W-1:0]     day;
  logic [MONTH_W-1:0]   month;
  logic [YEAR_W-1:0]    year;
  logic                 load_error;
  logic                 year_wrapped;

  date_cmd_t            date_cmds[$];
  date_result_t         pending_dates[$];

  // Predicted calendar state.
  logic [DAY_W-1:0]     cal_day;
  logic [MONTH_W-1:0]   cal_month;
  logic [YEAR_W-1:0]    cal_year;

  int                   next_cmd = 0;
  int                   send_gap = 0;
  bit                   tx_quiet = 1'b0;
  int                   rx_count = 0;
  int                   stall_left = 0;
  bit                   rx_quiet = 1'b0;
  int                   fail_cnt = 0;
  int                   idle_cycles = 0;
  bit                   timed_out = 1'b0;
  date_result_t         predicted;
  date_result_t         want;

  always #1 clk = ~clk;

  gregorian_date_advance DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .load_day     (load_day),
    .load_month   (load_month),
    .load_year    (load_year),
    .advance_days (advance_days),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .day          (day),
    .month        (month),
    .year         (year),
    .load_error   (load_error),
    .year_wrapped (year_wrapped)
  );

  // Month length under the 4/100/400 leap rule; zero for a code that is no month.
  function automatic int unsigned days_in_month(logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
    int unsigned yr = y;
    case (m)
      MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL, MONTH_AUG, MONTH_OCT, MONTH_DEC: return 31;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
      MONTH_FEB: return ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0) ? 29 : 28;
      default: return 0;
    endcase
  endfunction

  // Applies one transaction to the predicted calendar and returns the date it yields.
  function automatic date_result_t apply_to_calendar(date_cmd_t c);
    date_result_t r;
    int unsigned  left;
    int unsigned  room;
    int unsigned  len;
    r.load_error   = 1'b0;
    r.year_wrapped = 1'b0;
    if (c.act == ACT_LOAD) begin
      len = days_in_month(c.lm, c.ly);
      if (len == 0 || c.ld == 0 || c.ld > len) begin
        r.load_error = 1'b1;
      end else begin
        cal_day   = c.ld;
        cal_month = c.lm;
        cal_year  = c.ly;
      end
    end else begin
      // Whole rest-of-month spans are consumed until the count fits the month.
      left = c.adv;
      while (left != 0) begin
        len  = days_in_month(cal_month, cal_year);
        room = len - cal_day;
        if (left <= room) begin
          cal_day = cal_day + left;
          left    = 0;
        end else begin
          left    = left - (room + 1);
          cal_day = 1;
          if (cal_month != MONTH_DEC) begin
            cal_month = cal_month + 1;
          end else begin
            cal_month = MONTH_JAN;
            if (cal_year == YEAR_MAX) begin
              cal_year       = '0;
              r.year_wrapped = 1'b1;
            end else begin
              cal_year = cal_year + 1;
            end
          end
        end
      end
    end
    r.day   = cal_day;
    r.month = cal_month;
    r.year  = cal_year;
    return r;
  endfunction

  task automatic add_cmd(logic act, logic [DAY_W-1:0] ld, logic [MONTH_W-1:0] lm,
                         logic [YEAR_W-1:0] ly, logic [ADV_W-1:0] adv);
    date_cmd_t c;
    c.act          = act;
    c.ld           = ld;
    c.lm           = lm;
    c.ly           = ly;
    c.adv          = adv;
    c.known_result = 1'b0;
    c.want         = '{default: '0};
    date_cmds.push_back(c);
  endtask

  task automatic add_known(logic act, logic [DAY_W-1:0] ld, logic [MONTH_W-1:0] lm,
                           logic [YEAR_W-1:0] ly, logic [ADV_W-1:0] adv,
                           logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                           logic [YEAR_W-1:0] y, logic err, logic wrap);
    date_cmd_t c;
    add_cmd(act, ld, lm, ly, adv);
    c = date_cmds.pop_back();
    c.known_result = 1'b1;
    c.want         = '{day: d, month: m, year: y, load_error: err, year_wrapped: wrap};
    date_cmds.push_back(c);
  endtask

  // Years biased toward the century and leap-rule boundaries.
  function automatic logic [YEAR_W-1:0] pick_year();
    int unsigned r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 65535);
    if (r < 75) return $urandom_range(0, 655) * 100;
    if (r < 90) return $urandom_range(0, 16383) * 4;
    return ($urandom_range(0, 1) == 1) ? YEAR_MAX : '0;
  endfunction

  // Advance counts: mostly short, a few across the whole range.
  function automatic logic [ADV_W-1:0] pick_span();
    int unsigned r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 60);
    if (r < 88) return $urandom_range(61, 800);
    if (r < 95) return $urandom_range(801, 6000);
    return $urandom_range(0, 65535);
  endfunction

  // Directed rows, then random valid loads with a few advances, any loads, lone advances.
  initial begin
    int unsigned kind;
    int unsigned m;
    int unsigned y;
    int unsigned len;
    int          goal;
    add_known(ACT_ADVANCE, 0, 0, 0, 0, 1, MONTH_JAN, 0, 0, 0);
    add_known(ACT_LOAD, 29, MONTH_FEB, 2000, 0, 29, MONTH_FEB, 2000, 0, 0);
    add_known(ACT_LOAD, 29, MONTH_FEB, 1900, 0, 29, MONTH_FEB, 2000, 1, 0);
    add_known(ACT_LOAD, 29, MONTH_FEB, 2024, 0, 29, MONTH_FEB, 2024, 0, 0);
    add_known(ACT_LOAD, 29, MONTH_FEB, 2023, 0, 29, MONTH_FEB, 2024, 1, 0);
    add_known(ACT_LOAD, 1, 0, 2024, 0, 29, MONTH_FEB, 2024, 1, 0);
    add_known(ACT_LOAD, 1, 13, 2024, 0, 29, MONTH_FEB, 2024, 1, 0);
    add_known(ACT_LOAD, 31, 15, 65535, 65535, 29, MONTH_FEB, 2024, 1, 0);
    add_known(ACT_LOAD, 0, MONTH_JAN, 2024, 0, 29, MONTH_FEB, 2024, 1, 0);
    add_known(ACT_LOAD, 31, MONTH_APR, 2024, 0, 29, MONTH_FEB, 2024, 1, 0);
    add_known(ACT_LOAD, 31, MONTH_DEC, 65535, 0, 31, MONTH_DEC, 65535, 0, 0);
    add_known(ACT_ADVANCE, 31, 15, 65535, 1, 1, MONTH_JAN, 0, 0, 1);
    add_known(ACT_ADVANCE, 0, 0, 0, 0, 1, MONTH_JAN, 0, 0, 0);
    add_cmd(ACT_ADVANCE, 0, 0, 0, 65535);
    add_known(ACT_LOAD, 28, MONTH_FEB, 1900, 0, 28, MONTH_FEB, 1900, 0, 0);
    add_cmd(ACT_ADVANCE, 0, 0, 0, 1);
    add_known(ACT_LOAD, 28, MONTH_FEB, 2000, 0, 28, MONTH_FEB, 2000, 0, 0);
    add_cmd(ACT_ADVANCE, 0, 0, 0, 1);
    add_known(ACT_LOAD, 1, MONTH_JAN, 65530, 0, 1, MONTH_JAN, 65530, 0, 0);
    add_cmd(ACT_ADVANCE, 0, 0, 0, 65535);
    add_known(ACT_LOAD, 30, MONTH_NOV, 2024, 0, 30, MONTH_NOV, 2024, 0, 0);
    add_cmd(ACT_ADVANCE, 0, 0, 0, 31);
    add_cmd(ACT_ADVANCE, 0, 0, 0, 365);

    goal = date_cmds.size() + RANDOM_ITEMS;
    while (date_cmds.size() < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // Valid load followed by a short run of advances.
        m   = $urandom_range(1, 12);
        y   = pick_year();
        len = days_in_month(m, y);
        add_cmd(ACT_LOAD, $urandom_range(1, len), m, y, $urandom);
        repeat ($urandom_range(1, 4)) add_cmd(ACT_ADVANCE, $urandom, $urandom, $urandom, pick_span());
      end else if (kind < 75) begin
        // Late in one of the last two years, so that an advance may wrap the year.
        m   = $urandom_range(10, 12);
        y   = YEAR_MAX - $urandom_range(0, 1);
        len = days_in_month(m, y);
        add_cmd(ACT_LOAD, $urandom_range(1, len), m, y, $urandom);
        add_cmd(ACT_ADVANCE, $urandom, $urandom, $urandom, $urandom_range(0, 800));
      end else if (kind < 90) begin
        // Load with unconstrained fields, often rejected.
        add_cmd(ACT_LOAD, $urandom_range(0, 31), $urandom_range(0, 15), $urandom, $urandom);
      end else begin
        add_cmd(ACT_ADVANCE, $urandom, $urandom, $urandom, pick_span());
      end
    end
  end

  // Input side: predicts each accepted transaction and draws the gap before the next.
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      cal_day   = 1;
      cal_month = MONTH_JAN;
      cal_year  = '0;
      send_gap  = $urandom_range(0, 4);
    end else begin
      if (in_valid && !in_stall) begin
        predicted = apply_to_calendar(date_cmds[next_cmd]);
        pending_dates.push_back(date_cmds[next_cmd].known_result ?
                                date_cmds[next_cmd].want : predicted);
        next_cmd++;
        if (next_cmd % 32 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
        send_gap = tx_quiet ? 0 : $urandom_range(0, 4);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap == 0 && next_cmd < date_cmds.size()) begin
          in_valid     <= 1'b1;
          action       <= date_cmds[next_cmd].act;
          load_day     <= date_cmds[next_cmd].ld;
          load_month   <= date_cmds[next_cmd].lm;
          load_year    <= date_cmds[next_cmd].ly;
          advance_days <= date_cmds[next_cmd].adv;
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // Output side: checks each accepted result against the oldest expected date.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_dates.size() == 0) begin
          if (fail_cnt < MAX_REPORTS)
            $display("unexpected result: %0d/%0d/%0d err=%b wrap=%b",
                     day, month, year, load_error, year_wrapped);
          fail_cnt++;
        end else begin
          want = pending_dates.pop_front();
          if (day !== want.day || month !== want.month || year !== want.year ||
              load_error !== want.load_error || year_wrapped !== want.year_wrapped) begin
            if (fail_cnt < MAX_REPORTS)
              $display("mismatch: expected %0d/%0d/%0d err=%b wrap=%b, got %0d/%0d/%0d err=%b wrap=%b",
                       want.day, want.month, want.year, want.load_error, want.year_wrapped,
                       day, month, year, load_error, year_wrapped);
            fail_cnt++;
          end
        end
        rx_count++;
        if (rx_count % 32 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        stall_left = rx_quiet ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Reset, wait for every transaction to complete, then report.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (!(next_cmd == date_cmds.size() && pending_dates.size() == 0) && !timed_out) begin
      @(negedge clk);
      if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
    end
    if (timed_out) begin
      $display("FAIL");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (fail_cnt == 0 && pending_dates.size() == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
    end
    $finish;
  end

endmodule
